@@ design/ctue_pkg.sv @@
package ctue_pkg;

	localparam int ACC_W = 38;

	typedef logic signed [ACC_W-1:0] acc_t;

	typedef struct packed {
		logic clr;
		logic add;
	} acc_ctl_t;

	localparam logic [11:0] YEAR0 = 12'd1970;
	localparam logic [1:0]  YEAR0_MOD4 = 2'd2;
	localparam logic [6:0]  YEAR0_MOD100 = 7'd70;
	localparam logic [8:0]  YEAR0_MOD400 = 9'd370;

	localparam acc_t SEC_PER_DAY = acc_t'(86400);
	localparam acc_t SEC_PER_HOUR = acc_t'(3600);
	localparam acc_t SEC_PER_MIN = acc_t'(60);
	localparam acc_t SEC_PER_ZONE_Q = acc_t'(900);
	localparam acc_t SEC_PER_YEAR = acc_t'(365 * 86400);
	localparam acc_t SEC_PER_LEAP_YEAR = acc_t'(366 * 86400);

	function automatic logic is_leap(logic [11:0] y);
		logic [22:0] prod;
		logic [7:0]  quo;
		logic [11:0] rem;
		logic        div25;
		prod = 23'(y) * 23'd1311;
		quo = prod[22:15];
		rem = y - 12'({4'b0000, quo} * 12'd25);
		div25 = (rem == 12'd0);
		return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
	endfunction

	function automatic logic [8:0] days_before(logic [3:0] m);
		logic [8:0] d;
		unique case (m)
			4'd2:  d = 9'd31;
			4'd3:  d = 9'd59;
			4'd4:  d = 9'd90;
			4'd5:  d = 9'd120;
			4'd6:  d = 9'd151;
			4'd7:  d = 9'd181;
			4'd8:  d = 9'd212;
			4'd9:  d = 9'd243;
			4'd10: d = 9'd273;
			4'd11: d = 9'd304;
			4'd12: d = 9'd334;
			4'd13, 4'd14, 4'd15: d = 9'd365;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

@@ design/calendar_to_utc_epoch.sv @@
// One shared accumulating adder sums seconds under a small sequencer.
// After an accepted start the sequencer adds each whole year from 1970 up to
// year_full, then the month, day, hour, minute, second and zone terms.
// No new start is accepted until done; busy stays high meanwhile.
// The result is shown for one cycle with done; the receiver cannot stall.
// Asynchronous active-low reset returns the sequencer to idle with no strobe.
module calendar_to_utc_epoch (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [11:0]       year_full,
	input  logic [3:0]        month_num,
	input  logic [4:0]        day_of_month,
	input  logic [4:0]        hour_num,
	input  logic [5:0]        minute_num,
	input  logic [5:0]        second_num,
	input  logic signed [6:0] zone_quarters,
	output logic              done,
	output logic [31:0]       epoch_seconds
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_YEARS = 4'd1;
	localparam logic [3:0] ST_MONTH = 4'd2;
	localparam logic [3:0] ST_DAY   = 4'd3;
	localparam logic [3:0] ST_HOUR  = 4'd4;
	localparam logic [3:0] ST_MIN   = 4'd5;
	localparam logic [3:0] ST_SEC   = 4'd6;
	localparam logic [3:0] ST_ZONE  = 4'd7;
	localparam logic [3:0] ST_OUT   = 4'd8;

	logic [3:0]        state_q;
	logic [11:0]       year_q;
	logic [11:0]       ycnt_q;
	logic [3:0]        month_q;
	logic [4:0]        day_q;
	logic [4:0]        hour_q;
	logic [5:0]        minute_q;
	logic [5:0]        second_q;
	logic signed [6:0] zone_q;
	logic              leap_q;
	logic [1:0]        m4_q;
	logic [6:0]        m100_q;
	logic [8:0]        m400_q;
	logic              done_q;
	logic [31:0]       epoch_q;

	logic              accept;
	logic              more_years;
	logic              leap_loop;
	logic [8:0]        mdays;
	logic signed [6:0] dm1;
	ctue_pkg::acc_ctl_t ctl;
	ctue_pkg::acc_t     opnd;
	ctue_pkg::acc_t     acc;

	assign accept = start && !busy;
	assign busy = (state_q != ST_IDLE);
	assign more_years = (ycnt_q < year_q);
	assign leap_loop = (m4_q == 2'd0) && ((m100_q != 7'd0) || (m400_q == 9'd0));
	assign mdays = ctue_pkg::days_before(month_q) + 9'(leap_q && (month_q > 4'd2));
	assign dm1 = $signed({2'b00, day_q}) - 7'sd1;

	always_comb begin
		ctl.clr = accept;
		ctl.add = 1'b0;
		opnd = '0;
		unique case (state_q)
			ST_YEARS: begin
				ctl.add = more_years;
				opnd = leap_loop ? ctue_pkg::SEC_PER_LEAP_YEAR : ctue_pkg::SEC_PER_YEAR;
			end
			ST_MONTH: begin
				ctl.add = 1'b1;
				opnd = ctue_pkg::acc_t'($signed({1'b0, mdays})) * ctue_pkg::SEC_PER_DAY;
			end
			ST_DAY: begin
				ctl.add = 1'b1;
				opnd = ctue_pkg::acc_t'(dm1) * ctue_pkg::SEC_PER_DAY;
			end
			ST_HOUR: begin
				ctl.add = 1'b1;
				opnd = ctue_pkg::acc_t'($signed({1'b0, hour_q})) * ctue_pkg::SEC_PER_HOUR;
			end
			ST_MIN: begin
				ctl.add = 1'b1;
				opnd = ctue_pkg::acc_t'($signed({1'b0, minute_q})) * ctue_pkg::SEC_PER_MIN;
			end
			ST_SEC: begin
				ctl.add = 1'b1;
				opnd = ctue_pkg::acc_t'($signed({1'b0, second_q}));
			end
			ST_ZONE: begin
				ctl.add = 1'b1;
				opnd = -(ctue_pkg::acc_t'(zone_q) * ctue_pkg::SEC_PER_ZONE_Q);
			end
			default: begin
				ctl.add = 1'b0;
			end
		endcase
	end

	ctue_acc u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.opnd   (opnd),
		.acc    (acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_YEARS;
					end
				end
				ST_YEARS: begin
					if (!more_years) begin
						state_q <= ST_MONTH;
					end
				end
				ST_MONTH: state_q <= ST_DAY;
				ST_DAY:   state_q <= ST_HOUR;
				ST_HOUR:  state_q <= ST_MIN;
				ST_MIN:   state_q <= ST_SEC;
				ST_SEC:   state_q <= ST_ZONE;
				ST_ZONE:  state_q <= ST_OUT;
				ST_OUT: begin
					state_q <= ST_IDLE;
					done_q <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			year_q <= year_full;
			month_q <= month_num;
			day_q <= day_of_month;
			hour_q <= hour_num;
			minute_q <= minute_num;
			second_q <= second_num;
			zone_q <= zone_quarters;
			leap_q <= ctue_pkg::is_leap(year_full);
			ycnt_q <= ctue_pkg::YEAR0;
			m4_q <= ctue_pkg::YEAR0_MOD4;
			m100_q <= ctue_pkg::YEAR0_MOD100;
			m400_q <= ctue_pkg::YEAR0_MOD400;
		end else if ((state_q == ST_YEARS) && more_years) begin
			ycnt_q <= ycnt_q + 12'd1;
			m4_q <= m4_q + 2'd1;
			m100_q <= (m100_q == 7'd99) ? 7'd0 : m100_q + 7'd1;
			m400_q <= (m400_q == 9'd399) ? 9'd0 : m400_q + 9'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT) begin
			if (acc[ctue_pkg::ACC_W-1]) begin
				epoch_q <= '0;
			end else if (acc[ctue_pkg::ACC_W-2:32] != '0) begin
				epoch_q <= '1;
			end else begin
				epoch_q <= acc[31:0];
			end
		end
	end

	assign done = done_q;
	assign epoch_seconds = epoch_q;

`ifndef SYNTHESIS
	a_done_after_out: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == ST_OUT))
		else $error("done strobe without a finished sequence");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == ST_IDLE))
		else $error("done strobe while still busy");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_YEARS))
		else $error("accepted transfer did not start the year loop");

	a_year_bound: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_YEARS) && (year_q >= ctue_pkg::YEAR0)) |-> (ycnt_q <= year_q))
		else $error("year counter ran past the target year");
`endif

endmodule

@@ design/ctue_acc.sv @@
module ctue_acc (
	input  logic              clk,
	input  logic              arst_n,
	input  ctue_pkg::acc_ctl_t ctl,
	input  ctue_pkg::acc_t     opnd,
	output ctue_pkg::acc_t     acc
);

	ctue_pkg::acc_t acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.clr) begin
			acc_q <= '0;
		end else if (ctl.add) begin
			acc_q <= acc_q + opnd;
		end
	end

	assign acc = acc_q;

endmodule
